@@ rtl/core/dns_qname_encoder_macros.svh @@
// Assertion macros shared by the host name encoder
`ifndef DNS_QNAME_ENCODER_MACROS_SVH
`define DNS_QNAME_ENCODER_MACROS_SVH

// check a consequent in the same cycle as its antecedent
`define DQE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dns_qname_encoder: same-cycle check failed");

// check a consequent in the cycle after its antecedent
`define DQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dns_qname_encoder: next-cycle check failed");

`endif

@@ rtl/core/dnsq_pkg.sv @@
// Types and character constants for the host name encoder
package dnsq_pkg;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;
	localparam logic [7:0] TERM_BYTE = 8'h00;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LEN  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_DAT  = 5'b01000,
		ST_TERM = 5'b10000
	} state_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			r = c + CASE_OFS;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/dnsq_label_ram.sv @@
// Label buffer: one write port, one read port, registered read data
module dnsq_label_ram #(
	parameter int DEPTH = 62,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/dns_qname_encoder.sv @@
// Host name to DNS wire form encoder: top level with control and output register
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    ch, name_end
//   out      out  out_valid/out_stall  out_byte, last_byte, label_overflow
//
// An input beat is taken only while idle, when no label or terminator is released.
// A released label sends its length byte, then for each character a buffer read
// followed by an output load; the terminator byte is sent last when the name ends.
// The buffer read data is registered, so each character needs its read step first.
// Reset clears control state only; buffer contents are not cleared.
// A stalled output holds the current byte and the release waits on it.
`include "dns_qname_encoder_macros.svh"

module dns_qname_encoder #(
	parameter int MAX_LABEL = 62
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       name_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_byte,
	output logic       label_overflow
);

	import dnsq_pkg::*;

	localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
	localparam int CW = $clog2(MAX_LABEL + 1);

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          end_q;
	logic [AW-1:0] idx_q;
	logic          out_valid_q;

	logic          in_acc;
	logic          is_dot;
	logic          full;
	logic          out_free;
	logic          wr_en;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [7:0]    rd_data;
	logic [CW-1:0] count_nxt;
	logic          ovf_nxt;
	logic          last_char;
	logic          load;
	logic [7:0]    load_byte;
	logic          load_last;
	logic          load_ovf;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_dot    = (ch == CH_DOT);
	assign full      = (count_q >= CW'(MAX_LABEL));
	assign out_free  = !out_valid_q || !out_stall;
	assign wr_en     = in_acc && !is_dot && !full;
	assign wr_data   = fold_case(ch);
	assign rd_en     = (state_q == ST_RD);
	assign last_char = ((CW'(idx_q) + CW'(1)) == count_q);

	always_comb begin
		count_nxt = count_q;
		ovf_nxt   = ovf_q;
		if (!is_dot) begin
			if (full) begin
				ovf_nxt = 1'b1;
			end else begin
				count_nxt = count_q + CW'(1);
			end
		end
	end

	dnsq_label_ram #(
		.DEPTH (MAX_LABEL),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_comb begin
		load      = 1'b0;
		load_byte = rd_data;
		load_last = 1'b0;
		load_ovf  = ovf_q;
		case (state_q)
			ST_LEN: begin
				load      = out_free;
				load_byte = 8'(count_q);
			end
			ST_DAT: begin
				load = out_free;
			end
			ST_TERM: begin
				load      = out_free;
				load_byte = TERM_BYTE;
				load_last = 1'b1;
				load_ovf  = 1'b0;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			end_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= count_nxt;
						ovf_q   <= ovf_nxt;
						end_q   <= name_end;
						idx_q   <= '0;
						if ((is_dot || name_end) && count_nxt != '0) begin
							state_q <= ST_LEN;
						end else if (name_end) begin
							state_q <= ST_TERM;
						end
					end
				end
				ST_LEN: begin
					if (out_free) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_DAT;
				end
				ST_DAT: begin
					if (out_free) begin
						if (last_char) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= end_q ? ST_TERM : ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_TERM: begin
					if (out_free) begin
						end_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte       <= load_byte;
			last_byte      <= load_last;
			label_overflow <= load_ovf;
		end
	end

	assign out_valid = out_valid_q;

	`DQE_ASSERT_NOW(a_term_clean, clk, arst_n, out_valid && last_byte,
		out_byte == TERM_BYTE && !label_overflow)
	`DQE_ASSERT_NOW(a_flush_nonempty, clk, arst_n,
		state_q == ST_LEN || state_q == ST_RD || state_q == ST_DAT, count_q != '0)
	`DQE_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_LABEL))
	`DQE_ASSERT_NEXT(a_rd_hold, clk, arst_n, state_q == ST_DAT && !out_free,
		state_q == ST_DAT && $stable(rd_data))

endmodule
